// File: hw/rtl/sfir_pkg.sv
// ----------------------------------------------------------------------------
// sfir_pkg
// Shared constants, types and helpers of the separable FIR image filter.
// ----------------------------------------------------------------------------
`default_nettype none

package sfir_pkg;

	localparam int RADIUS     = 2;
	localparam int NTAPS      = 2 * RADIUS + 1;
	localparam int DEPTH      = 2 * RADIUS;
	localparam int MAX_WIDTH  = 2048;
	localparam int COL_W      = $clog2(MAX_WIDTH);
	localparam int ROWS_W     = $clog2(DEPTH + 1);
	localparam int PIX_W      = 8;
	localparam int COEF_W     = 16;
	localparam int FRAC       = 14;
	localparam int PROD_W     = PIX_W + COEF_W;
	localparam int SUM_W      = PROD_W + $clog2(NTAPS);
	localparam int PIX_MAX    = 255;

	localparam int NUM_TAP_REGS = 5;
	localparam int LINE_WIDTH_W = 12;
	localparam int WCMP_W       = (LINE_WIDTH_W > COL_W + 1) ? LINE_WIDTH_W : COL_W + 1;
	localparam int CFG_IDX_W    = 3;
	localparam int CFG_DATA_W   = 16;

	localparam logic [CFG_IDX_W-1:0] REG_TAP_0      = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_TAP_1      = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_TAP_2      = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_TAP_3      = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_TAP_4      = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_LINE_WIDTH = 3'd5;

	localparam logic [COEF_W-1:0]       TAP_CENTER_RESET = 16'd16384;
	localparam logic [LINE_WIDTH_W-1:0] LINE_WIDTH_RESET = 12'd2048;

	typedef logic [PIX_W-1:0] pix_t;
	typedef pix_t [NTAPS-1:0] win_t;
	typedef logic [NTAPS-1:0][COEF_W-1:0] coefs_t;
	typedef logic [NUM_TAP_REGS-1:0][COEF_W-1:0] taps_t;
	typedef logic [DEPTH*PIX_W-1:0] line_word_t;

	// All taps zero but the center one.
	localparam taps_t TAPS_RESET =
		taps_t'({TAP_CENTER_RESET, {(REG_TAP_2 * COEF_W){1'b0}}});

	typedef struct packed {
		logic             valid;
		logic [COL_W-1:0] col;
		pix_t             pix;
	} lb_req_t;

	// Coefficient at kernel position pos; positions beyond the registers are zero.
	function automatic logic [COEF_W-1:0] coef_at(taps_t taps, int pos);
		int idx;
		idx = pos - RADIUS + 2;
		if (idx < 0 || idx >= NUM_TAP_REGS) begin
			return '0;
		end
		return taps[idx];
	endfunction

endpackage

`default_nettype wire

// File: hw/rtl/separable_fir_image_filter_top.sv
// ----------------------------------------------------------------------------
// separable_fir_image_filter_top
// Streaming separable 5x5 FIR image filter with line store and output skid.
// ----------------------------------------------------------------------------
// The block takes one pixel per clock in raster order while not stalled and
// gives one filtered pixel for each input pixel whose vertical and horizontal
// windows lie inside the frame. A result goes through the line store read,
// both filter passes and the output register. The rate is set by the single
// column word of the line store, read, shifted and written back per pixel.
// The line store needs no clearing pass after reset. A two-entry output stage
// keeps accepting input while a result waits to be taken, and input stalls
// only once both entries are full. Configuration writes are taken at any time
// but must only be made while the block is idle.
// ----------------------------------------------------------------------------
`default_nettype none

module separable_fir_image_filter_top (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              in_valid,
	output logic                                   in_ready,
	input  wire logic [7:0]                        pixel_in,
	input  wire logic                              frame_start,
	output logic                                   out_valid,
	input  wire logic                              out_ready,
	output logic [7:0]                             pixel_out,
	output logic                                   row_last,
	input  wire logic                              cfg_valid,
	output logic                                   cfg_ready,
	input  wire logic [sfir_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  wire logic [sfir_pkg::CFG_DATA_W-1:0]   cfg_data
);

	typedef struct packed {
		logic valid;
		logic vert_ok;
		logic out_ok;
		logic last;
	} ctl_t;

	sfir_pkg::taps_t                    taps;
	logic [sfir_pkg::LINE_WIDTH_W-1:0]  line_width;
	sfir_pkg::coefs_t                   coefs;

	logic                               en;
	logic                               accept;
	logic [sfir_pkg::COL_W-1:0]         cc_q;
	logic [sfir_pkg::ROWS_W-1:0]        rows_q;
	logic [sfir_pkg::COL_W-1:0]         cc_eff;
	logic [sfir_pkg::ROWS_W-1:0]        rows_eff;
	logic [sfir_pkg::WCMP_W-1:0]        lw_ext;
	logic [sfir_pkg::WCMP_W-1:0]        w_eff;
	logic [sfir_pkg::WCMP_W-1:0]        cc_ext;
	logic [sfir_pkg::WCMP_W-1:0]        col_full;
	logic [sfir_pkg::COL_W-1:0]         col;
	ctl_t                               ctl_in;
	ctl_t                               ctl_s1, ctl_s2, ctl_s3, ctl_s4, ctl_s5;

	sfir_pkg::lb_req_t                  lb_req;
	sfir_pkg::win_t                     col_win;
	sfir_pkg::win_t                     vsamp;
	sfir_pkg::pix_t                     vres;
	sfir_pkg::pix_t [sfir_pkg::DEPTH-1:0] hwin_q;
	sfir_pkg::win_t                     hsamp;
	sfir_pkg::pix_t                     hres;

	logic                               out_v_q;
	sfir_pkg::pix_t                     out_pix_q;
	logic                               out_last_q;
	logic                               skid_v_q;
	sfir_pkg::pix_t                     skid_pix_q;
	logic                               skid_last_q;
	logic                               push;

	assign cfg_ready = 1'b1;

	sfir_cfg u_cfg (
		.clk        (clk),
		.arst_n     (arst_n),
		.wr_en      (cfg_valid),
		.wr_index   (cfg_index),
		.wr_data    (cfg_data),
		.taps       (taps),
		.line_width (line_width)
	);

	always_comb begin
		for (int t = 0; t < sfir_pkg::NTAPS; t++) begin
			coefs[t] = sfir_pkg::coef_at(taps, t);
		end
	end

	// Column and row bookkeeping at the input transfer.
	assign en       = !skid_v_q;
	assign in_ready = en;
	assign accept   = in_valid && en;

	assign cc_eff   = frame_start ? '0 : cc_q;
	assign rows_eff = frame_start ? '0 : rows_q;
	assign lw_ext   = sfir_pkg::WCMP_W'(line_width);
	assign cc_ext   = sfir_pkg::WCMP_W'(cc_eff);

	always_comb begin
		if (lw_ext > sfir_pkg::WCMP_W'(sfir_pkg::MAX_WIDTH)) begin
			w_eff = sfir_pkg::WCMP_W'(sfir_pkg::MAX_WIDTH);
		end else if (lw_ext == '0) begin
			w_eff = sfir_pkg::WCMP_W'(1);
		end else begin
			w_eff = lw_ext;
		end
		col_full = (cc_ext >= w_eff) ? w_eff - sfir_pkg::WCMP_W'(1) : cc_ext;
	end

	assign col            = col_full[sfir_pkg::COL_W-1:0];
	assign ctl_in.valid   = accept;
	assign ctl_in.vert_ok = rows_eff >= sfir_pkg::ROWS_W'(sfir_pkg::DEPTH);
	assign ctl_in.out_ok  = ctl_in.vert_ok && (col_full >= sfir_pkg::WCMP_W'(sfir_pkg::DEPTH));
	assign ctl_in.last    = (col_full + sfir_pkg::WCMP_W'(1)) >= w_eff;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cc_q   <= '0;
			rows_q <= '0;
		end else if (accept) begin
			if (ctl_in.last) begin
				cc_q   <= '0;
				rows_q <= ctl_in.vert_ok ? rows_eff : rows_eff + sfir_pkg::ROWS_W'(1);
			end else begin
				cc_q   <= col + sfir_pkg::COL_W'(1);
				rows_q <= rows_eff;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
			ctl_s2 <= '0;
			ctl_s3 <= '0;
			ctl_s4 <= '0;
			ctl_s5 <= '0;
		end else if (en) begin
			ctl_s1 <= ctl_in;
			ctl_s2 <= ctl_s1;
			ctl_s3 <= ctl_s2;
			ctl_s4 <= ctl_s3;
			ctl_s5 <= ctl_s4;
		end
	end

	// Vertical pass over the column of the line store.
	assign lb_req.valid = accept;
	assign lb_req.col   = col;
	assign lb_req.pix   = pixel_in;

	sfir_lbuf u_lbuf (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.req     (lb_req),
		.col_win (col_win)
	);

	assign vsamp = ctl_s1.vert_ok ? col_win : '0;

	sfir_fir u_vfir (
		.clk     (clk),
		.en      (en),
		.samples (vsamp),
		.coefs   (coefs),
		.result  (vres)
	);

	// Horizontal pass over the most recent vertical results.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hwin_q <= '0;
		end else if (en && ctl_s3.valid) begin
			for (int k = sfir_pkg::DEPTH - 1; k > 0; k--) begin
				hwin_q[k] <= hwin_q[k-1];
			end
			hwin_q[0] <= vres;
		end
	end

	always_comb begin
		for (int t = 0; t < sfir_pkg::DEPTH; t++) begin
			hsamp[t] = hwin_q[sfir_pkg::DEPTH-1-t];
		end
		hsamp[sfir_pkg::DEPTH] = vres;
	end

	sfir_fir u_hfir (
		.clk     (clk),
		.en      (en),
		.samples (hsamp),
		.coefs   (coefs),
		.result  (hres)
	);

	// Output register with a skid entry behind it.
	assign push = en && ctl_s5.valid && ctl_s5.out_ok;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q  <= 1'b0;
			skid_v_q <= 1'b0;
		end else begin
			if (out_v_q && out_ready && skid_v_q) begin
				skid_v_q <= 1'b0;
			end else if (push) begin
				if (!out_v_q || out_ready) begin
					out_v_q <= 1'b1;
				end else begin
					skid_v_q <= 1'b1;
				end
			end else if (out_ready) begin
				out_v_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (out_v_q && out_ready && skid_v_q) begin
			out_pix_q  <= skid_pix_q;
			out_last_q <= skid_last_q;
		end else if (push) begin
			if (!out_v_q || out_ready) begin
				out_pix_q  <= hres;
				out_last_q <= ctl_s5.last;
			end else begin
				skid_pix_q  <= hres;
				skid_last_q <= ctl_s5.last;
			end
		end
	end

	assign out_valid = out_v_q;
	assign pixel_out = out_pix_q;
	assign row_last  = out_last_q;

	a_skid_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_v_q |-> out_v_q)
		else $error("Skid entry is full while the output register is empty.");

	a_rows_saturate: assert property (@(posedge clk) disable iff (!arst_n)
		rows_q <= sfir_pkg::ROWS_W'(sfir_pkg::DEPTH))
		else $error("Row count went past the window depth.");

	a_push_lands: assert property (@(posedge clk) disable iff (!arst_n)
		push |=> out_v_q)
		else $error("A finished result did not reach the output register.");

	a_skid_drains: assert property (@(posedge clk) disable iff (!arst_n)
		(out_v_q && out_ready && skid_v_q) |=> (out_v_q && !skid_v_q))
		else $error("The skid entry did not move to the output register.");

endmodule

`default_nettype wire

// File: hw/rtl/sfir_cfg.sv
// ----------------------------------------------------------------------------
// sfir_cfg
// Configuration registers: five kernel taps and the line width.
// ----------------------------------------------------------------------------
`default_nettype none

module sfir_cfg (
	input  wire                                logic clk,
	input  wire                                logic arst_n,
	input  wire                                logic wr_en,
	input  wire  logic [sfir_pkg::CFG_IDX_W-1:0]  wr_index,
	input  wire  logic [sfir_pkg::CFG_DATA_W-1:0] wr_data,
	output sfir_pkg::taps_t                       taps,
	output logic [sfir_pkg::LINE_WIDTH_W-1:0]     line_width
);

	sfir_pkg::taps_t                       taps_q;
	logic [sfir_pkg::LINE_WIDTH_W-1:0]     line_width_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			taps_q <= sfir_pkg::TAPS_RESET;
			line_width_q <= sfir_pkg::LINE_WIDTH_RESET;
		end else if (wr_en) begin
			unique case (wr_index) inside
				sfir_pkg::REG_TAP_0, sfir_pkg::REG_TAP_1, sfir_pkg::REG_TAP_2,
				sfir_pkg::REG_TAP_3, sfir_pkg::REG_TAP_4: begin
					taps_q[wr_index] <= wr_data;
				end
				sfir_pkg::REG_LINE_WIDTH: begin
					line_width_q <= wr_data[sfir_pkg::LINE_WIDTH_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	assign taps       = taps_q;
	assign line_width = line_width_q;

endmodule

`default_nettype wire

// File: hw/rtl/sfir_lbuf.sv
// ----------------------------------------------------------------------------
// sfir_lbuf
// Line store: one word per column holding the pixels of the rows above,
// updated by read, shift and write back, with forwarding between transfers
// that hit the same column in consecutive enabled cycles.
// ----------------------------------------------------------------------------
`default_nettype none

module sfir_lbuf (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              en,
	input  wire sfir_pkg::lb_req_t req,
	output sfir_pkg::win_t         col_win
);

	sfir_pkg::line_word_t mem [sfir_pkg::MAX_WIDTH];
	sfir_pkg::line_word_t rdata_q;
	sfir_pkg::line_word_t fwd_word_q;
	sfir_pkg::line_word_t old_word;
	sfir_pkg::line_word_t new_word;
	logic                           fwd_q;
	logic                           v_s1;
	logic [sfir_pkg::COL_W-1:0]     col_s1;
	sfir_pkg::pix_t                 pix_s1;

	assign old_word = fwd_q ? fwd_word_q : rdata_q;
	assign new_word = {old_word[sfir_pkg::DEPTH*sfir_pkg::PIX_W-sfir_pkg::PIX_W-1:0], pix_s1};

	always_ff @(posedge clk) begin
		if (en && req.valid) begin
			rdata_q <= mem[req.col];
		end
		if (en && v_s1) begin
			mem[col_s1] <= new_word;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			col_s1     <= req.col;
			pix_s1     <= req.pix;
			fwd_word_q <= new_word;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1  <= 1'b0;
			fwd_q <= 1'b0;
		end else if (en) begin
			v_s1  <= req.valid;
			fwd_q <= req.valid && v_s1 && (req.col == col_s1);
		end
	end

	always_comb begin
		for (int t = 0; t < sfir_pkg::DEPTH; t++) begin
			col_win[t] = old_word[(sfir_pkg::DEPTH-1-t)*sfir_pkg::PIX_W +: sfir_pkg::PIX_W];
		end
		col_win[sfir_pkg::DEPTH] = pix_s1;
	end

endmodule

`default_nettype wire

// File: hw/rtl/sfir_fir.sv
// ----------------------------------------------------------------------------
// sfir_fir
// One filter pass: registered products, then sum, clamp to 0..255 and
// truncation of the Q1.14 fraction.
// ----------------------------------------------------------------------------
`default_nettype none

module sfir_fir (
	input  wire logic             clk,
	input  wire logic             en,
	input  wire sfir_pkg::win_t   samples,
	input  wire sfir_pkg::coefs_t coefs,
	output sfir_pkg::pix_t        result
);

	logic signed [sfir_pkg::PROD_W-1:0]      prod_s1 [sfir_pkg::NTAPS];
	logic signed [sfir_pkg::SUM_W-1:0]       sum;
	logic [sfir_pkg::SUM_W-sfir_pkg::FRAC-2:0] quot;
	sfir_pkg::pix_t                          clamped;
	sfir_pkg::pix_t                          res_s2;

	always_ff @(posedge clk) begin
		if (en) begin
			for (int t = 0; t < sfir_pkg::NTAPS; t++) begin
				prod_s1[t] <= $signed({1'b0, samples[t]}) * $signed(coefs[t]);
			end
		end
	end

	always_comb begin
		sum = '0;
		for (int t = 0; t < sfir_pkg::NTAPS; t++) begin
			sum = sum + sfir_pkg::SUM_W'(prod_s1[t]);
		end
		quot = sum[sfir_pkg::SUM_W-2:sfir_pkg::FRAC];
		if (sum[sfir_pkg::SUM_W-1]) begin
			clamped = '0;
		end else if (quot > (sfir_pkg::SUM_W-sfir_pkg::FRAC-1)'(sfir_pkg::PIX_MAX)) begin
			clamped = sfir_pkg::PIX_W'(sfir_pkg::PIX_MAX);
		end else begin
			clamped = quot[sfir_pkg::PIX_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			res_s2 <= clamped;
		end
	end

	assign result = res_s2;

endmodule

`default_nettype wire
